// ===== hw/rtl/tced_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tced_pkg
// Shared types and constants of the termcap escape decoder.
// ---------------------------------------------------------------------------
package tced_pkg;

  localparam logic [7:0] CHR_BSLASH = 8'h5C;
  localparam logic [7:0] CHR_CARET  = 8'h5E;
  localparam logic [7:0] CHR_E      = 8'h45;
  localparam logic [7:0] CHR_A      = 8'h61;
  localparam logic [7:0] CHR_B      = 8'h62;
  localparam logic [7:0] CHR_F      = 8'h66;
  localparam logic [7:0] CHR_N      = 8'h6E;
  localparam logic [7:0] CHR_R      = 8'h72;
  localparam logic [7:0] CHR_T      = 8'h74;
  localparam logic [7:0] CHR_OCT_LO = 8'h30;
  localparam logic [7:0] CHR_OCT_HI = 8'h37;

  localparam logic [7:0] CODE_ESC   = 8'h1B;
  localparam logic [7:0] CODE_BEL   = 8'h07;
  localparam logic [7:0] CODE_BS    = 8'h08;
  localparam logic [7:0] CODE_FF    = 8'h0C;
  localparam logic [7:0] CODE_LF    = 8'h0A;
  localparam logic [7:0] CODE_CR    = 8'h0D;
  localparam logic [7:0] CODE_HT    = 8'h09;
  localparam logic [7:0] CTRL_MASK  = 8'h1F;
  localparam logic [7:0] CTRL_NUL   = 8'h80;
  localparam logic [7:0] TERM_BYTE  = 8'h00;

  localparam int unsigned MAX_RES = 3;

  typedef enum logic [4:0] {
    MODE_NORMAL = 5'b00001,
    MODE_BSLASH = 5'b00010,
    MODE_CARET  = 5'b00100,
    MODE_OCT1   = 5'b01000,
    MODE_OCT2   = 5'b10000
  } tced_mode_t;

  typedef struct packed {
    logic [1:0]                cnt;
    logic [MAX_RES-1:0][7:0]   bytes;
    logic                      term;
  } tced_res_t;

endpackage

// ===== hw/rtl/tced_decode.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tced_decode
// Escape state and single-pass decode of one registered byte into up to
// three result bytes.
// ---------------------------------------------------------------------------
module tced_decode (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic [7:0]         byte_i,
  input  logic               last_i,
  output tced_pkg::tced_res_t res
);

  tced_pkg::tced_mode_t mode_r, mode_nxt;
  logic [7:0]           oct_r, oct_nxt;

  always_comb begin
    logic       is_oct;
    logic [1:0] n;
    logic [7:0] v;
    is_oct   = (byte_i >= tced_pkg::CHR_OCT_LO) && (byte_i <= tced_pkg::CHR_OCT_HI);
    n        = 2'd0;
    v        = byte_i & tced_pkg::CTRL_MASK;
    res      = '0;
    mode_nxt = tced_pkg::MODE_NORMAL;
    oct_nxt  = oct_r;

    case (mode_r)
      tced_pkg::MODE_BSLASH: begin
        case (byte_i)
          tced_pkg::CHR_E: begin res.bytes[n] = tced_pkg::CODE_ESC; n = n + 2'd1; end
          tced_pkg::CHR_A: begin res.bytes[n] = tced_pkg::CODE_BEL; n = n + 2'd1; end
          tced_pkg::CHR_B: begin res.bytes[n] = tced_pkg::CODE_BS;  n = n + 2'd1; end
          tced_pkg::CHR_F: begin res.bytes[n] = tced_pkg::CODE_FF;  n = n + 2'd1; end
          tced_pkg::CHR_N: begin res.bytes[n] = tced_pkg::CODE_LF;  n = n + 2'd1; end
          tced_pkg::CHR_R: begin res.bytes[n] = tced_pkg::CODE_CR;  n = n + 2'd1; end
          tced_pkg::CHR_T: begin res.bytes[n] = tced_pkg::CODE_HT;  n = n + 2'd1; end
          default: begin
            if (is_oct) begin
              oct_nxt  = {5'd0, byte_i[2:0]};
              mode_nxt = tced_pkg::MODE_OCT1;
            end else begin
              res.bytes[n] = byte_i;
              n = n + 2'd1;
            end
          end
        endcase
      end
      tced_pkg::MODE_CARET: begin
        res.bytes[n] = (v == 8'd0) ? tced_pkg::CTRL_NUL : v;
        n = n + 2'd1;
      end
      tced_pkg::MODE_OCT1, tced_pkg::MODE_OCT2: begin
        if (is_oct && mode_r == tced_pkg::MODE_OCT1) begin
          oct_nxt  = {oct_r[4:0], byte_i[2:0]};
          mode_nxt = tced_pkg::MODE_OCT2;
        end else if (is_oct) begin
          res.bytes[n] = {oct_r[4:0], byte_i[2:0]};
          n = n + 2'd1;
          oct_nxt = 8'd0;
        end else begin
          // flush pending value, then treat byte as plain
          res.bytes[n] = oct_r;
          n = n + 2'd1;
          oct_nxt = 8'd0;
          if (byte_i == tced_pkg::CHR_BSLASH) begin
            mode_nxt = tced_pkg::MODE_BSLASH;
          end else if (byte_i == tced_pkg::CHR_CARET) begin
            mode_nxt = tced_pkg::MODE_CARET;
          end else begin
            res.bytes[n] = byte_i;
            n = n + 2'd1;
          end
        end
      end
      default: begin
        if (byte_i == tced_pkg::CHR_BSLASH) begin
          mode_nxt = tced_pkg::MODE_BSLASH;
        end else if (byte_i == tced_pkg::CHR_CARET) begin
          mode_nxt = tced_pkg::MODE_CARET;
        end else begin
          res.bytes[n] = byte_i;
          n = n + 2'd1;
        end
      end
    endcase

    if (last_i) begin
      if (mode_nxt == tced_pkg::MODE_OCT1 || mode_nxt == tced_pkg::MODE_OCT2) begin
        res.bytes[n] = oct_nxt;
        n = n + 2'd1;
      end
      res.bytes[n] = tced_pkg::TERM_BYTE;
      n = n + 2'd1;
      res.term = 1'b1;
      mode_nxt = tced_pkg::MODE_NORMAL;
      oct_nxt  = 8'd0;
    end
    res.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= tced_pkg::MODE_NORMAL;
      oct_r  <= 8'd0;
    end else if (adv) begin
      mode_r <= mode_nxt;
      oct_r  <= oct_nxt;
    end
  end

endmodule

// ===== hw/rtl/tced_out_buf.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tced_out_buf
// Result register holding up to three decoded bytes, shifted out one item
// per cycle while out_stall is low.
// ---------------------------------------------------------------------------
module tced_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  tced_pkg::tced_res_t res,
  input  logic                out_stall,
  output logic                free,
  output logic                out_valid,
  output logic [7:0]          out_byte,
  output logic                out_last
);

  logic [tced_pkg::MAX_RES-1:0][7:0] q_r, q_nxt;
  logic [1:0]                        cnt_r, cnt_nxt;
  logic                              term_r, term_nxt;
  logic                              pop;

  assign out_valid = (cnt_r != 2'd0);
  assign out_byte  = q_r[0];
  assign out_last  = term_r && (cnt_r == 2'd1);
  assign pop       = out_valid && !out_stall;
  assign free      = (cnt_r == 2'd0) || (cnt_r == 2'd1 && !out_stall);

  always_comb begin
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    term_nxt = term_r;
    if (load) begin
      q_nxt    = res.bytes;
      cnt_nxt  = res.cnt;
      term_nxt = res.term;
    end else if (pop) begin
      q_nxt   = {8'd0, q_r[tced_pkg::MAX_RES-1:1]};
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 2'd0;
      term_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      term_r <= term_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

endmodule

// ===== hw/rtl/termcap_escape_decoder_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// termcap_escape_decoder_unit
// Decodes termcap string escapes, one raw byte per input item.
// ---------------------------------------------------------------------------
// input channel: in_valid/in_stall carry in_byte and in_last (final byte of
// a string). output channel: out_valid/out_stall carry out_byte and out_last
// (set only on the zero terminator closing the string).
// an accepted item is held in an input register; once the result register is
// free, its decoded bytes (zero to three) are loaded into the result register,
// which presents the first result to the output channel.
// throughput is one item per cycle while each item yields at most one byte
// and out_stall is low; an item yielding more bytes occupies the result
// register until the single output port has drained it, one byte per cycle.
// reset clears the escape state and the valid state of the input register
// and the result register; no item is in flight after reset.
// when the receiver stalls, the output byte is held, the result register
// fills and in_stall is raised once the input register cannot advance.
// ---------------------------------------------------------------------------
module termcap_escape_decoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic                in_vld_r, in_vld_nxt;
  logic [7:0]          byte_r;
  logic                last_r;
  logic                free;
  logic                adv;
  logic                take;
  tced_pkg::tced_res_t res;

  assign adv      = in_vld_r && free;
  assign in_stall = in_vld_r && !free;
  assign take     = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (take) begin
      in_vld_nxt = 1'b1;
    end else if (adv) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_byte;
      last_r <= in_last;
    end
  end

  tced_decode u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .byte_i (byte_r),
    .last_i (last_r),
    .res    (res)
  );

  tced_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv),
    .res       (res),
    .out_stall (out_stall),
    .free      (free),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule
